### rtl/core/bdc_pkg.sv
// Package for the Banker's algorithm safety checker.
// Holds the default sizes, the operation and register codes and the item types.
// No dependencies; bankers_deadlock_check refers to it by scoped names.

package bdc_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int MAX_PROCESSES = 16;
    localparam int MAX_RESOURCES = 8;
    localparam int VALUE_BITS    = 16;

    // Fixed field widths of the item channels.
    localparam int OPERATION_BITS  = 2;
    localparam int PROC_IDX_BITS   = 4;
    localparam int RES_IDX_BITS    = 3;
    localparam int VALUE_FIELD_BITS = 16;
    localparam int STUCK_COUNT_BITS = 5;
    localparam int STUCK_MASK_BITS  = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 5;
    localparam int PROC_COUNT_BITS = 5;
    localparam int RES_COUNT_BITS  = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROCESS_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESOURCE_COUNT = 1'b1;
    localparam logic [PROC_COUNT_BITS-1:0] PROC_COUNT_RESET = 5'd16;
    localparam logic [RES_COUNT_BITS-1:0]  RES_COUNT_RESET  = 4'd8;

    // Operation codes carried by an input item.
    typedef enum logic [OPERATION_BITS-1:0] {
        OP_WRITE_MAX   = 2'd0,
        OP_WRITE_ALLOC = 2'd1,
        OP_WRITE_AVAIL = 2'd2,
        OP_RUN_CHECK   = 2'd3
    } op_t;

    // Input item.
    typedef struct packed {
        op_t                         operation;
        logic [PROC_IDX_BITS-1:0]    process_index;
        logic [RES_IDX_BITS-1:0]     resource_index;
        logic [VALUE_FIELD_BITS-1:0] value;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic                        deadlock_present;
        logic [STUCK_COUNT_BITS-1:0] stuck_count;
        logic [STUCK_MASK_BITS-1:0]  stuck_mask;
    } out_item_t;

endpackage

### rtl/core/bdc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the claim and allocation tables of the safety checker.
// Depends on nothing.

module bdc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bankers_deadlock_check.sv
// Banker's algorithm safety checker: table loads and the run sequencer.
// Depends on bdc_pkg and on bdc_ram for the claim and allocation tables.
// A write item is taken while idle and the next item may follow at once.
// A run stalls the input while it scans the processes, checks each need column by
// column, adds each granted allocation to the work vector column by column and posts
// the result; at most nproc*(nproc+1)/2 checks. The tables' single read port serialises the columns.
// Reset clears the control state and the work vector; the tables hold nothing until written.

module bankers_deadlock_check #(
    parameter int MAX_PROCESSES = bdc_pkg::MAX_PROCESSES,
    parameter int MAX_RESOURCES = bdc_pkg::MAX_RESOURCES,
    parameter int VALUE_BITS    = bdc_pkg::VALUE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [bdc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bdc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // Input channel
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  bdc_pkg::in_item_t                     item,
    // Result channel
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output bdc_pkg::out_item_t                    result
);

    // Derived widths.
    localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CW  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCW = $clog2(MAX_PROCESSES + 1);
    localparam int NCW = $clog2(MAX_RESOURCES + 1);
    localparam int AW  = PW + CW;
    localparam int TABLE_DEPTH = 1 << AW;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CHECK = 5'b00100,
        S_ADD   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                               state_reg, state_next;
    logic [bdc_pkg::PROC_COUNT_BITS-1:0]  proc_count_reg;
    logic [bdc_pkg::RES_COUNT_BITS-1:0]   res_count_reg;
    logic [PCW-1:0]                       nproc;
    logic [NCW-1:0]                       nres;

    logic [PCW-1:0]        p_reg, p_next;
    logic [NCW-1:0]        col_reg, col_next;
    logic                  pend_reg, pend_next;
    logic [CW-1:0]         pend_col_reg, pend_col_next;
    logic                  fit_reg, fit_next;
    logic [PCW-1:0]        fin_cnt_reg;
    logic [MAX_PROCESSES-1:0] finished_reg;
    logic [VALUE_BITS-1:0] work_reg  [MAX_RESOURCES];
    logic [VALUE_BITS-1:0] avail_reg [MAX_RESOURCES];

    logic                  item_accept;
    logic                  run_start;
    logic                  we_max, we_alloc, we_avail;
    logic                  idx_ok_p, idx_ok_c;
    logic [AW-1:0]         waddr, raddr;
    logic [VALUE_BITS-1:0] wvalue;
    logic [VALUE_BITS-1:0] max_rd, alloc_rd;
    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS-1:0] sum_sat;
    logic                  last_col;
    logic                  work_we;
    logic                  fin_set;
    logic                  result_load;
    logic [MAX_PROCESSES-1:0] stuck_full;

    bdc_pkg::out_item_t    result_reg;
    logic                  result_valid_reg;

    // Counts in use, saturated into their legal ranges.
    always_comb
    begin
        if (proc_count_reg == '0)
        begin
            nproc = PCW'(1);
        end
        else if (32'(proc_count_reg) > MAX_PROCESSES)
        begin
            nproc = PCW'(MAX_PROCESSES);
        end
        else
        begin
            nproc = PCW'(proc_count_reg);
        end

        if (res_count_reg == '0)
        begin
            nres = NCW'(1);
        end
        else if (32'(res_count_reg) > MAX_RESOURCES)
        begin
            nres = NCW'(MAX_RESOURCES);
        end
        else
        begin
            nres = NCW'(res_count_reg);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_count_reg <= bdc_pkg::PROC_COUNT_RESET;
            res_count_reg  <= bdc_pkg::RES_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdc_pkg::CFG_PROCESS_COUNT:
                begin
                    proc_count_reg <= cfg_data[bdc_pkg::PROC_COUNT_BITS-1:0];
                end
                bdc_pkg::CFG_RESOURCE_COUNT:
                begin
                    res_count_reg <= cfg_data[bdc_pkg::RES_COUNT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Input handshake and table write decode; out-of-range writes are dropped.
    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign idx_ok_p    = (32'(item.process_index) < MAX_PROCESSES);
    assign idx_ok_c    = (32'(item.resource_index) < MAX_RESOURCES);
    assign we_max      = item_accept && (item.operation == bdc_pkg::OP_WRITE_MAX)
                         && idx_ok_p && idx_ok_c;
    assign we_alloc    = item_accept && (item.operation == bdc_pkg::OP_WRITE_ALLOC)
                         && idx_ok_p && idx_ok_c;
    assign we_avail    = item_accept && (item.operation == bdc_pkg::OP_WRITE_AVAIL)
                         && idx_ok_c;
    assign run_start   = item_accept && (item.operation == bdc_pkg::OP_RUN_CHECK);
    assign waddr       = {PW'(item.process_index), CW'(item.resource_index)};
    assign wvalue      = VALUE_BITS'(item.value);
    assign raddr       = {p_reg[PW-1:0], col_reg[CW-1:0]};

    // Claim and allocation tables.
    bdc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_max_ram (
        .clk   (clk),
        .we    (we_max),
        .waddr (waddr),
        .wdata (wvalue),
        .raddr (raddr),
        .rdata (max_rd)
    );

    bdc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_alloc_ram (
        .clk   (clk),
        .we    (we_alloc),
        .waddr (waddr),
        .wdata (wvalue),
        .raddr (raddr),
        .rdata (alloc_rd)
    );

    // One adder serves both the fit test (max <= alloc + work) and the saturating add.
    assign sum      = {1'b0, alloc_rd} + {1'b0, work_reg[pend_col_reg]};
    assign sum_sat  = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];
    assign last_col = pend_reg && (pend_col_reg == CW'(nres - NCW'(1)));

    // Sequencer: scan for the next unfinished process, check its need, add if it fits, then rescan from 0.
    always_comb
    begin
        state_next    = state_reg;
        p_next        = p_reg;
        col_next      = col_reg;
        pend_next     = 1'b0;
        pend_col_next = pend_col_reg;
        fit_next      = fit_reg;
        work_we       = 1'b0;
        fin_set       = 1'b0;
        result_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (run_start)
                begin
                    state_next = S_SCAN;
                    p_next     = '0;
                end
            end
            S_SCAN:
            begin
                if (p_reg == nproc)
                begin
                    state_next = S_DONE;
                end
                else if (finished_reg[p_reg[PW-1:0]])
                begin
                    p_next = p_reg + PCW'(1);
                end
                else
                begin
                    state_next = S_CHECK;
                    col_next   = '0;
                    fit_next   = 1'b1;
                end
            end
            S_CHECK, S_ADD:
            begin
                // Issue one column read a cycle.
                if (col_reg < nres)
                begin
                    col_next      = col_reg + NCW'(1);
                    pend_next     = 1'b1;
                    pend_col_next = col_reg[CW-1:0];
                end
                if (state_reg == S_CHECK)
                begin
                    if (pend_reg)
                    begin
                        fit_next = fit_reg && ({1'b0, max_rd} <= sum);
                    end
                    if (last_col)
                    begin
                        if (fit_next)
                        begin
                            state_next = S_ADD;
                            col_next   = '0;
                            pend_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                            p_next     = p_reg + PCW'(1);
                        end
                    end
                end
                else
                begin
                    work_we = pend_reg;
                    if (last_col)
                    begin
                        fin_set    = 1'b1;
                        state_next = S_SCAN;
                        p_next     = '0;
                    end
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer and finished-mask registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            p_reg        <= '0;
            col_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_col_reg <= '0;
            fit_reg      <= 1'b1;
            fin_cnt_reg  <= '0;
            finished_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p_reg        <= p_next;
            col_reg      <= col_next;
            pend_reg     <= pend_next;
            pend_col_reg <= pend_col_next;
            fit_reg      <= fit_next;
            if (run_start)
            begin
                fin_cnt_reg  <= '0;
                finished_reg <= '0;
            end
            else if (fin_set)
            begin
                fin_cnt_reg                 <= fin_cnt_reg + PCW'(1);
                finished_reg[p_reg[PW-1:0]] <= 1'b1;
            end
        end
    end

    // Work vector: loaded from the available vector at a run, updated by the add pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else if (run_start)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                work_reg[i] <= avail_reg[i];
            end
        end
        else if (work_we)
        begin
            work_reg[pend_col_reg] <= sum_sat;
        end
    end

    // Available vector.
    always_ff @(posedge clk)
    begin
        if (we_avail)
        begin
            avail_reg[CW'(item.resource_index)] <= wvalue;
        end
    end

    // Processes in use that are not finished.
    always_comb
    begin
        for (int i = 0; i < MAX_PROCESSES; i++)
        begin
            stuck_full[i] = (i < int'(nproc)) && !finished_reg[i];
        end
    end

    // Result register; it parts the sequencer from the result channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg.deadlock_present <= (fin_cnt_reg != nproc);
            result_reg.stuck_count      <= bdc_pkg::STUCK_COUNT_BITS'(nproc - fin_cnt_reg);
            result_reg.stuck_mask       <= bdc_pkg::STUCK_MASK_BITS'(stuck_full);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The finished count always tracks the finished mask.
    a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(finished_reg) == int'(fin_cnt_reg))
        else $error("finished count disagrees with finished mask");

    // No more processes finish than are in use.
    a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (fin_cnt_reg <= nproc))
        else $error("finished count exceeds process count");

    // The add pass is only entered for a process whose need fitted.
    a_add_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) |-> fit_reg)
        else $error("add pass without a fitting need");

    // A new result appears only at the end of a run.
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the end of a run");

endmodule
